### design/rmth_pkg.sv
`default_nettype none
package rmth_pkg;
	localparam int CAPACITY_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PUSH_RD,
		ST_PUSH_CMP,
		ST_DOWN_RD,
		ST_DOWN_CMP,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### design/running_median_two_heaps.sv
`default_nettype none
// Sequence: an accepted input item passes the decision state. When the store is full it is rejected
// and the decision state goes straight to the result state; else a push follows (a read and a
// compare-write per level), and where a top crosses heaps, a replace-top (a read and a compare-write per level).
// Flow: one item at a time; s_tready is high only in the idle state, so a new item is taken only
// after the result item of the last one has been accepted.
// Reset: arst_n clears the sizes, tops and control state; heap memory is undefined until written.
module running_median_two_heaps #(
	parameter int CAPACITY = rmth_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = rmth_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // value[31:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // median_doubled[32:0], count[43:33], zeros
	output logic             m_tuser    // rejected
);
	import rmth_pkg::*;

	localparam int DEPTH = (CAPACITY + 1) / 2;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = $clog2(DEPTH + 1);
	localparam int CW = $clog2(CAPACITY + 1);
	// Index width: room for the right child of the deepest entry.
	localparam int IW = AW + 2;
	// Stored width: one extra bit so negated values fit in the upper heap.
	localparam int DW = VALUE_WIDTH + 1;

	logic signed [DW-1:0] mem_l [DEPTH];
	logic signed [DW-1:0] mem_u [DEPTH];
	logic signed [DW-1:0] rla_q, rlb_q, rua_q, rub_q;

	state_t state_q, state_d;
	logic [SW-1:0] lsize_q, usize_q;
	logic signed [DW-1:0] ltop_q, utop_q;   // copies of entry zero of each heap
	logic signed [DW-1:0] v_q;              // value being pushed or sifted
	logic signed [DW-1:0] pv_q;             // value of the pending replace-top
	logic sel_q;                            // 0: lower heap, 1: upper heap
	logic psel_q;
	logic pend_q;                           // a replace-top follows the push
	logic rej_q;
	logic [IW-1:0] idx_q;

	logic we;
	logic [AW-1:0] wa, ra_a, ra_b;
	logic signed [DW-1:0] wd;
	logic op_done, climb;
	logic signed [DW-1:0] vin, rda, rdb, bv_l, down_val;
	logic [IW-1:0] par, lch, rch, hsz, bi_l, down_idx;
	logic l_ok, r_ok, down_move;
	logic [CW-1:0] total;
	logic lower_side;
	logic signed [DW:0] med_wide;

	// Heap memories with registered reads at two addresses.
	always_ff @(posedge clk) begin
		if (we && !sel_q) mem_l[wa] <= wd;
		if (we && sel_q) mem_u[wa] <= wd;
		rla_q <= mem_l[ra_a];
		rlb_q <= mem_l[ra_b];
		rua_q <= mem_u[ra_a];
		rub_q <= mem_u[ra_b];
	end

	assign vin = DW'(signed'(s_tdata[VALUE_WIDTH-1:0]));
	assign rda = sel_q ? rua_q : rla_q;
	assign rdb = sel_q ? rub_q : rlb_q;

	// Heap index arithmetic.
	assign par = (idx_q - IW'(1)) >> 1;
	assign lch = {idx_q[IW-2:0], 1'b1};
	assign rch = lch + IW'(1);
	assign hsz = sel_q ? IW'(usize_q) : IW'(lsize_q);
	assign total = CW'(lsize_q) + CW'(usize_q);
	assign lower_side = (lsize_q == '0) || (v_q <= ltop_q);

	// Sift-down choice: the largest of the value and the children in range.
	assign l_ok = (lch < hsz) && (rda > v_q);
	assign bv_l = l_ok ? rda : v_q;
	assign bi_l = l_ok ? lch : idx_q;
	assign r_ok = (rch < hsz) && (rdb > bv_l);
	assign down_val = r_ok ? rdb : bv_l;
	assign down_idx = r_ok ? rch : bi_l;
	assign down_move = l_ok || r_ok;

	// Twice the median of the held set.
	always_comb begin
		if (lsize_q == '0) med_wide = '0;
		else if (lsize_q > usize_q) med_wide = {ltop_q, 1'b0};
		else med_wide = (DW+1)'(ltop_q) - (DW+1)'(utop_q);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = {4'b0, 11'(total), 33'(med_wide)};
	assign m_tuser = rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and memory control: each heap step is a read state followed by a compare-write state.
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		wa = '0;
		wd = v_q;
		ra_a = '0;
		ra_b = '0;
		op_done = 1'b0;
		climb = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = rej_q ? ST_OUT : ST_PUSH_RD;
			end
			ST_PUSH_RD: begin
				if (idx_q == '0) begin
					we = 1'b1;
					op_done = 1'b1;
				end else begin
					ra_a = AW'(par);
					state_d = ST_PUSH_CMP;
				end
			end
			ST_PUSH_CMP: begin
				// Bubble up: the parent value is in rda.
				we = 1'b1;
				wa = AW'(idx_q);
				if (rda >= v_q) begin
					op_done = 1'b1;
				end else begin
					wd = rda;
					climb = 1'b1;
					state_d = ST_PUSH_RD;
				end
			end
			ST_DOWN_RD: begin
				ra_a = AW'(lch);
				ra_b = AW'(rch);
				state_d = ST_DOWN_CMP;
			end
			ST_DOWN_CMP: begin
				we = 1'b1;
				wa = AW'(idx_q);
				if (down_move) begin
					wd = down_val;
					state_d = ST_DOWN_RD;
				end else begin
					op_done = 1'b1;
				end
			end
			ST_OUT: begin
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (op_done) state_d = pend_q ? ST_DOWN_RD : ST_OUT;
	end

	// Data registers of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsize_q <= '0;
			usize_q <= '0;
			ltop_q <= '0;
			utop_q <= '0;
			v_q <= '0;
			pv_q <= '0;
			sel_q <= 1'b0;
			psel_q <= 1'b0;
			pend_q <= 1'b0;
			rej_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (we && wa == '0) begin
				if (sel_q) utop_q <= wd;
				else ltop_q <= wd;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						v_q <= vin;
						rej_q <= total >= CW'(CAPACITY);
					end
				end
				ST_DECIDE: begin
					if (!rej_q) begin
						if (lower_side) begin
							if (lsize_q > usize_q) begin
								// Lower top crosses up, the value replaces it.
								sel_q <= 1'b1;
								v_q <= -ltop_q;
								idx_q <= IW'(usize_q);
								usize_q <= usize_q + SW'(1);
								pend_q <= 1'b1;
								pv_q <= v_q;
								psel_q <= 1'b0;
							end else begin
								sel_q <= 1'b0;
								idx_q <= IW'(lsize_q);
								lsize_q <= lsize_q + SW'(1);
								pend_q <= 1'b0;
							end
						end else if (usize_q >= lsize_q) begin
							if (usize_q != '0 && -utop_q < v_q) begin
								// Upper top crosses down, the value replaces it.
								sel_q <= 1'b0;
								v_q <= -utop_q;
								idx_q <= IW'(lsize_q);
								lsize_q <= lsize_q + SW'(1);
								pend_q <= 1'b1;
								pv_q <= -v_q;
								psel_q <= 1'b1;
							end else begin
								sel_q <= 1'b0;
								idx_q <= IW'(lsize_q);
								lsize_q <= lsize_q + SW'(1);
								pend_q <= 1'b0;
							end
						end else begin
							sel_q <= 1'b1;
							v_q <= -v_q;
							idx_q <= IW'(usize_q);
							usize_q <= usize_q + SW'(1);
							pend_q <= 1'b0;
						end
					end
				end
				ST_PUSH_CMP: begin
					if (climb) idx_q <= par;
				end
				ST_DOWN_CMP: begin
					if (down_move) idx_q <= down_idx;
				end
				default: ;
			endcase
			// Second operation: replace the top of the other heap.
			if (op_done && pend_q) begin
				sel_q <= psel_q;
				v_q <= pv_q;
				idx_q <= '0;
				pend_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire
